### sv/lfel_pkg.sv
// Shared constants, types and helpers for the link fault event logger.
package lfel_pkg;

  localparam int NUM_LINKS   = 14;
  localparam int EVENT_DEPTH = 64;
  localparam int FAULT_BITS  = 24;

  localparam int LINK_W  = 4;
  localparam int FAULT_W = 24;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;
  localparam int CODE_W  = 3;
  localparam int BIT_W   = $clog2(FAULT_W);
  localparam int SLOT_W  = $clog2(EVENT_DEPTH);
  localparam int FILL_W  = $clog2(EVENT_DEPTH + 1);
  localparam int LINK_AW = $clog2(NUM_LINKS);

  localparam logic [FAULT_W-1:0] FAULT_MASK = FAULT_W'((64'(1) << FAULT_BITS) - 64'(1));
  localparam logic [CNT_W-1:0]   CNT_MAX    = '1;

  typedef enum logic [CODE_W-1:0] {
    EV_CONNECTED = 3'd0,
    EV_RESTORED  = 3'd1,
    EV_LOST      = 3'd2,
    EV_FAULT_ON  = 3'd3,
    EV_FAULT_OFF = 3'd4
  } ev_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CONN,
    ST_SCAN
  } state_t;

  // per-link diagnostic entry, held in the link table
  typedef struct packed {
    logic               live;
    logic               seen;
    logic [TIME_W-1:0]  since;
    logic [CNT_W-1:0]   drops;
    logic [CNT_W-1:0]   rises;
    logic [FAULT_W-1:0] bits;
  } link_entry_t;

  localparam int LINK_ENTRY_W = $bits(link_entry_t);

  // one ring entry: time, link, code, bit
  typedef struct packed {
    logic [BIT_W-1:0]  fidx;
    logic [CODE_W-1:0] code;
    logic [LINK_W-1:0] link;
    logic [TIME_W-1:0] time_ms;
  } ring_entry_t;

  localparam int RING_ENTRY_W = $bits(ring_entry_t);

  // input tdata layout, lowest field in the lowest bits
  typedef struct packed {
    logic [1:0]         pad;
    logic [TIME_W-1:0]  time_ms;
    logic               frame_valid;
    logic [FAULT_W-1:0] fault_map;
    logic               live_now;
    logic [LINK_W-1:0]  link;
  } in_beat_t;

  // output tdata layout, lowest field in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0]  fault_rise_count;
    logic [CNT_W-1:0]  drop_count;
    logic [CNT_W-1:0]  overwritten_total;
    logic              overwrote;
    logic [SLOT_W-1:0] slot;
    logic [BIT_W-1:0]  fault_index;
    logic [LINK_W-1:0] event_link;
    logic [TIME_W-1:0] event_time;
  } out_beat_t;

  localparam int IN_DATA_W  = $bits(in_beat_t);
  localparam int OUT_DATA_W = $bits(out_beat_t);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

### sv/lfel_ram.sv
// Generic single-port-write, registered-read RAM.
module lfel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/link_fault_event_logger.sv
// Top level of the link fault event logger: link table, event ring, event sequencer.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-------------------------------------------
//  in_      | in  | in_tvalid / in_tready  | tdata: link, live, fault map, frame ok, time
//  out_     | out | out_tvalid / out_tready| tdata: event fields and counters, tuser: code
//
// Ignored reports (link out of range, missing frame) are accepted and dropped. Other reports
// are accepted, then the link table entry is read in the load state, then a connection
// report emits its event, if any, or a fault report steps through the fault bits up to the highest
// changed bit (at most 24 bits), testing a single bit of the changed map per step.
// Reset clears the link table through per-entry valid bits at once; no clearing pass.
// A busy output register stalls the sequencer on the event it is about to emit.
module link_fault_event_logger (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // link[3:0], live_now[4], fault_map[28:5], frame_valid[29], time_ms[61:30], zero pad
  input  logic [lfel_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // event_time[31:0], event_link[35:32], fault_index[40:36], slot[46:41],
  // overwrote[47], overwritten_total[79:48], drop_count[111:80], fault_rise_count[143:112]
  output logic [lfel_pkg::OUT_DATA_W-1:0] out_tdata,
  // event_code[2:0]
  output logic [lfel_pkg::CODE_W-1:0]     out_tuser,
  output logic                            out_tlast
);
  import lfel_pkg::*;

  state_t state_r, state_nxt;

  in_beat_t in_beat;
  logic     take_ok;

  logic               req_kind_r, req_kind_nxt;
  logic [LINK_W-1:0]  req_link_r, req_link_nxt;
  logic               req_live_r, req_live_nxt;
  logic [FAULT_W-1:0] req_map_r, req_map_nxt;
  logic [TIME_W-1:0]  req_time_r, req_time_nxt;

  link_entry_t        work_r, work_nxt;
  logic [FAULT_W-1:0] changed_r, changed_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;

  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]  ovt_r, ovt_nxt;

  logic [NUM_LINKS-1:0] lnk_vld_r, lnk_vld_nxt;

  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_beat_r, out_beat_nxt;
  logic [CODE_W-1:0] out_code_r, out_code_nxt;
  logic              out_last_r, out_last_nxt;

  logic               lnk_re, lnk_we;
  logic [LINK_AW-1:0] lnk_raddr, lnk_waddr;
  link_entry_t        lnk_rdata, lnk_wdata;

  logic        ring_we;
  ring_entry_t ring_wdata;

  link_entry_t        entry_ld;
  logic [FAULT_W-1:0] changed_ld;
  logic               out_free, scan_hit, last_hit, conn_emit, scan_emit;
  logic [FAULT_W-1:0] remain;

  assign in_beat   = in_beat_t'(in_tdata);
  assign take_ok   = (32'(in_beat.link) < NUM_LINKS) && (!in_tuser || in_beat.frame_valid);
  assign in_tready = (state_r == ST_IDLE);

  assign lnk_re    = in_tvalid && in_tready && take_ok;
  assign lnk_raddr = LINK_AW'(in_beat.link);
  assign lnk_waddr = LINK_AW'(req_link_r);

  // a never-written entry reads as the reset value
  assign entry_ld   = lnk_vld_r[req_link_r] ? lnk_rdata : '0;
  assign changed_ld = (entry_ld.bits ^ req_map_r) & FAULT_MASK;

  assign out_free  = !out_valid_r || out_tready;
  assign scan_hit  = changed_r[bit_r];
  assign remain    = changed_r & ~(FAULT_W'(1) << bit_r);
  assign last_hit  = (remain == '0);
  assign conn_emit = (state_r == ST_CONN) && out_free;
  assign scan_emit = (state_r == ST_SCAN) && scan_hit && out_free;

  lfel_ram #(
    .WIDTH(LINK_ENTRY_W),
    .DEPTH(NUM_LINKS)
  ) u_link_ram (
    .clk  (clk),
    .we   (lnk_we),
    .waddr(lnk_waddr),
    .wdata(lnk_wdata),
    .re   (lnk_re),
    .raddr(lnk_raddr),
    .rdata(lnk_rdata)
  );

  lfel_ram #(
    .WIDTH(RING_ENTRY_W),
    .DEPTH(EVENT_DEPTH)
  ) u_ring_ram (
    .clk  (clk),
    .we   (ring_we),
    .waddr(head_r),
    .wdata(ring_wdata),
    .re   (1'b0),
    .raddr('0),
    .rdata()
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && take_ok) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!req_kind_r) begin
          state_nxt = (entry_ld.live != req_live_r) ? ST_CONN : ST_IDLE;
        end else begin
          state_nxt = (changed_ld != '0) ? ST_SCAN : ST_IDLE;
        end
      end
      ST_CONN: begin
        if (conn_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_emit && last_hit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    logic              emit;
    logic [CODE_W-1:0] code;
    logic              over;
    link_entry_t       upd;

    req_kind_nxt  = req_kind_r;
    req_link_nxt  = req_link_r;
    req_live_nxt  = req_live_r;
    req_map_nxt   = req_map_r;
    req_time_nxt  = req_time_r;
    work_nxt      = work_r;
    changed_nxt   = changed_r;
    bit_nxt       = bit_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    ovt_nxt       = ovt_r;
    lnk_vld_nxt   = lnk_vld_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    lnk_we        = 1'b0;
    lnk_wdata     = work_r;
    ring_we       = 1'b0;
    emit          = 1'b0;
    code          = EV_CONNECTED;
    upd           = work_r;

    if (in_tvalid && in_tready) begin
      req_kind_nxt = in_tuser;
      req_link_nxt = in_beat.link;
      req_live_nxt = in_beat.live_now;
      req_map_nxt  = in_beat.fault_map & FAULT_MASK;
      req_time_nxt = in_beat.time_ms;
    end

    unique case (state_r)
      ST_LOAD: begin
        work_nxt    = entry_ld;
        changed_nxt = changed_ld;
        bit_nxt     = '0;
      end
      ST_CONN: begin
        if (req_live_r) begin
          code       = work_r.seen ? EV_RESTORED : EV_CONNECTED;
          upd.seen   = 1'b1;
          upd.since  = req_time_r;
        end else begin
          code       = EV_LOST;
          upd.drops  = sat_inc(work_r.drops);
        end
        upd.live = req_live_r;
        if (conn_emit) begin
          emit      = 1'b1;
          lnk_we    = 1'b1;
          lnk_wdata = upd;
        end
      end
      ST_SCAN: begin
        if (req_map_r[bit_r]) begin
          code      = EV_FAULT_ON;
          upd.rises = sat_inc(work_r.rises);
        end else begin
          code      = EV_FAULT_OFF;
        end
        if (!scan_hit) begin
          bit_nxt = bit_r + BIT_W'(1);
        end else if (scan_emit) begin
          emit        = 1'b1;
          work_nxt    = upd;
          changed_nxt = remain;
          bit_nxt     = bit_r + BIT_W'(1);
          if (last_hit) begin
            upd.bits  = req_map_r;
            lnk_we    = 1'b1;
            lnk_wdata = upd;
          end
        end
      end
      default: begin
      end
    endcase

    if (lnk_we) begin
      lnk_vld_nxt[req_link_r] = 1'b1;
    end

    over = (fill_r == FILL_W'(EVENT_DEPTH));
    ring_wdata.fidx    = (state_r == ST_SCAN) ? bit_r : '0;
    ring_wdata.code    = code;
    ring_wdata.link    = req_link_r;
    ring_wdata.time_ms = req_time_r;

    if (emit) begin
      ring_we  = 1'b1;
      head_nxt = (head_r == SLOT_W'(EVENT_DEPTH - 1)) ? '0 : head_r + SLOT_W'(1);
      if (over) begin
        ovt_nxt = sat_inc(ovt_r);
      end else begin
        fill_nxt = fill_r + FILL_W'(1);
      end
      out_valid_nxt                  = 1'b1;
      out_beat_nxt.event_time        = req_time_r;
      out_beat_nxt.event_link        = req_link_r;
      out_beat_nxt.fault_index       = ring_wdata.fidx;
      out_beat_nxt.slot              = head_r;
      out_beat_nxt.overwrote         = over;
      out_beat_nxt.overwritten_total = over ? sat_inc(ovt_r) : ovt_r;
      out_beat_nxt.drop_count        = upd.drops;
      out_beat_nxt.fault_rise_count  = upd.rises;
      out_code_nxt                   = code;
      out_last_nxt                   = (state_r == ST_CONN) || last_hit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      ovt_r       <= '0;
      lnk_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      ovt_r       <= ovt_nxt;
      lnk_vld_r   <= lnk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_kind_r <= req_kind_nxt;
    req_link_r <= req_link_nxt;
    req_live_r <= req_live_nxt;
    req_map_r  <= req_map_nxt;
    req_time_r <= req_time_nxt;
    work_r     <= work_nxt;
    changed_r  <= changed_nxt;
    bit_r      <= bit_nxt;
    out_beat_r <= out_beat_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_beat_r;
  assign out_tuser  = out_code_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_lnk_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    lnk_we |-> (state_r == ST_CONN || state_r == ST_SCAN))
    else $error("link table written outside an emit state");

  a_lnk_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(lnk_we && lnk_re))
    else $error("link table read issued in the same cycle as a write-back");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(EVENT_DEPTH))
    else $error("ring fill count beyond depth");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |=> (out_valid_r && out_beat_r.slot == $past(head_r)))
    else $error("ring write without matching output beat");
`endif

endmodule
